// ----- rtl/grid_astar_path_planner_defines.svh -----
// Assertion macros shared by the planner RTL
`ifndef GRID_ASTAR_PATH_PLANNER_DEFINES_SVH
`define GRID_ASTAR_PATH_PLANNER_DEFINES_SVH
// Check that a condition implies a consequence on the same edge
`define GAP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Check that a condition implies a consequence at the following edge
`define GAP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ----- rtl/gap_pkg.sv -----
// Package: types and constants for the grid path planner
package gap_pkg;
  localparam int MapSize = 8;
  localparam int CoordW = 3;
  localparam int CellW = 6;
  localparam int NumCells = 64;
  localparam int PoolDepth = 1024;
  localparam int PoolAw = $clog2(PoolDepth);
  localparam int CntW = PoolAw + 1;
  localparam int CostW = 16;
  localparam logic [CostW-1:0] CostOrtho = 16'd1000;
  localparam logic [CostW-1:0] CostDiag = 16'd1414;
  localparam int MaxOut = 63;

  localparam logic [1:0] ST_PATH = 2'd0;
  localparam logic [1:0] ST_AT_TARGET = 2'd1;
  localparam logic [1:0] ST_BLOCKED = 2'd2;
  localparam logic [1:0] ST_NO_PATH = 2'd3;

  localparam logic KIND_WRITE = 1'b0;

  typedef struct packed {
    logic              kind;
    logic [CoordW-1:0] cell_x;
    logic [CoordW-1:0] cell_y;
    logic              wall;
    logic [CoordW-1:0] target_x;
    logic [CoordW-1:0] target_y;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [CoordW-1:0] path_x;
    logic [CoordW-1:0] path_y;
    logic              last;
  } out_item_t;

  typedef struct packed {
    logic [CellW-1:0]  pos;
    logic [CostW-1:0]  g;
    logic [CostW-1:0]  f;
    logic              has_parent;
    logic [PoolAw-1:0] parent;
  } node_t;

  function automatic logic [CostW-1:0] octile(input logic [CoordW-1:0] x,
                                              input logic [CoordW-1:0] y,
                                              input logic [CoordW-1:0] tx,
                                              input logic [CoordW-1:0] ty);
    logic [CoordW-1:0] dx, dy, mn, mx;
    dx = (x > tx) ? x - tx : tx - x;
    dy = (y > ty) ? y - ty : ty - y;
    mn = (dx < dy) ? dx : dy;
    mx = (dx < dy) ? dy : dx;
    return CostW'(CostOrtho * CostW'(mx - mn)) + CostW'(CostDiag * CostW'(mn));
  endfunction
endpackage

// ----- rtl/gap_if.sv -----
// Valid/ready channel interface for the planner
interface gap_if #(parameter type payload_t = logic) (input logic clk);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/grid_astar_path_planner.sv -----
// Top level: A* path planner over an 8x8 wall map with memory-held node pool
// Map write updates the wall map with no result; a status query registers its result
// in the cycle after transfer. Search: each pop sweeps the open list memory, reading
// every heap entry and then its node to find the lowest f, then expands that node.
// Path items leave one at a time; input waits until the last one transfers.
// Sync active-low reset clears map, closed marks and control; RAMs are read-first.
module grid_astar_path_planner (
  input logic clk,
  input logic rst_n,
  gap_if.sink   in_ch,
  gap_if.source out_ch
);
  import gap_pkg::*;
  `include "grid_astar_path_planner_defines.svh"

  typedef enum logic [11:0] {
    S_IDLE   = 12'b000000000001,
    S_CLEAR  = 12'b000000000010,
    S_SCAN   = 12'b000000000100,
    S_SCANRD = 12'b000000001000,
    S_POP    = 12'b000000010000,
    S_CUR    = 12'b000000100000,
    S_NBR    = 12'b000001000000,
    S_ADD    = 12'b000010000000,
    S_TRACE  = 12'b000100000000,
    S_EMIT   = 12'b001000000000,
    S_WAIT   = 12'b010000000000,
    S_FETCH  = 12'b100000000000
  } state_t;

  state_t state_r;
  logic [NumCells-1:0] wall_r, closed_r;
  node_t             pool_mem [PoolDepth];
  logic [PoolAw-1:0] heap_mem [PoolDepth];
  node_t             pool_rd_r;
  logic [PoolAw-1:0] heap_rd_r;

  logic [CntW-1:0]   node_cnt_r, heap_cnt_r, scan_r;
  logic [CoordW-1:0] tx_r, ty_r;
  logic [PoolAw-1:0] best_idx_r, best_pos_r, cur_r;
  logic [CostW-1:0]  best_f_r;
  logic              best_ok_r;
  logic [CellW-1:0]  cur_cell_r;
  logic [CostW-1:0]  cur_g_r;
  logic [2:0]        nbr_r;
  logic [5:0]        emit_cnt_r;
  logic              out_valid_r;
  out_item_t         out_r;
  logic              has_parent_r;
  logic [PoolAw-1:0] parent_r;

  // Pool port
  logic              pool_we;
  logic [PoolAw-1:0] pool_wa, pool_ra;
  node_t             pool_wd;
  // Heap port
  logic              heap_we;
  logic [PoolAw-1:0] heap_wa, heap_ra;
  logic [PoolAw-1:0] heap_wd;

  always_ff @(posedge clk) begin
    if (pool_we) pool_mem[pool_wa] <= pool_wd;
    pool_rd_r <= pool_mem[pool_ra];
    if (heap_we) heap_mem[heap_wa] <= heap_wd;
    heap_rd_r <= heap_mem[heap_ra];
  end

  // Neighbor offsets
  logic signed [2:0] ndx, ndy;
  always_comb begin
    case (nbr_r)
      3'd0: begin ndx = -3'sd1; ndy = -3'sd1; end
      3'd1: begin ndx = -3'sd1; ndy = 3'sd0; end
      3'd2: begin ndx = -3'sd1; ndy = 3'sd1; end
      3'd3: begin ndx = 3'sd0; ndy = -3'sd1; end
      3'd4: begin ndx = 3'sd0; ndy = 3'sd1; end
      3'd5: begin ndx = 3'sd1; ndy = -3'sd1; end
      3'd6: begin ndx = 3'sd1; ndy = 3'sd0; end
      default: begin ndx = 3'sd1; ndy = 3'sd1; end
    endcase
  end

  logic [CoordW-1:0] cx, cy;
  logic [CoordW:0]   nx4, ny4;
  logic [CoordW-1:0] nx, ny;
  logic              diag, nbr_ok;
  logic [CostW-1:0]  new_g;
  assign cx = cur_cell_r[CoordW-1:0];
  assign cy = cur_cell_r[CellW-1:CoordW];
  assign nx4 = {1'b0, cx} + {ndx[2], ndx};
  assign ny4 = {1'b0, cy} + {ndy[2], ndy};
  assign nx = nx4[CoordW-1:0];
  assign ny = ny4[CoordW-1:0];
  assign diag = (ndx != 3'sd0) && (ndy != 3'sd0);
  assign new_g = cur_g_r + (diag ? CostDiag : CostOrtho);
  always_comb begin
    nbr_ok = !nx4[CoordW] && !ny4[CoordW] && !wall_r[{ny, nx}] && !closed_r[{ny, nx}];
    if (diag && (wall_r[{cy, nx}] || wall_r[{ny, cx}])) nbr_ok = 1'b0;
  end

  logic pool_room;
  assign pool_room = (node_cnt_r < CntW'(PoolDepth)) && (heap_cnt_r < CntW'(PoolDepth));

  in_item_t in_d;
  assign in_d = in_ch.data;
  assign in_ch.ready = (state_r == S_IDLE) && !out_valid_r;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data = out_r;

  logic in_xfer, out_xfer;
  assign in_xfer = in_ch.valid && in_ch.ready;
  assign out_xfer = out_valid_r && out_ch.ready;

  logic last_scan;
  assign last_scan = (scan_r + 1'b1) >= heap_cnt_r;

  always_comb begin
    pool_we = 1'b0;
    pool_wa = node_cnt_r[PoolAw-1:0];
    pool_wd = '0;
    pool_ra = heap_rd_r;
    heap_we = 1'b0;
    heap_wa = heap_cnt_r[PoolAw-1:0];
    heap_wd = node_cnt_r[PoolAw-1:0];
    heap_ra = scan_r[PoolAw-1:0];
    case (state_r)
      S_CLEAR: begin
        pool_we = 1'b1;
        pool_wd.pos = {cy, cx};
        pool_wd.g = '0;
        pool_wd.f = octile(cx, cy, tx_r, ty_r);
        pool_wd.has_parent = 1'b0;
        pool_wd.parent = '0;
        heap_we = 1'b1;
      end
      S_POP: begin
        // move tail into hole
        heap_ra = PoolAw'(heap_cnt_r - 1'b1);
      end
      S_CUR: begin
        heap_we = 1'b1;
        heap_wa = best_pos_r;
        heap_wd = heap_rd_r;
        pool_ra = best_idx_r;
      end
      S_ADD: begin
        pool_we = 1'b1;
        pool_wd.pos = {ny, nx};
        pool_wd.g = new_g;
        pool_wd.f = new_g + octile(nx, ny, tx_r, ty_r);
        pool_wd.has_parent = 1'b1;
        pool_wd.parent = cur_r;
        heap_we = 1'b1;
      end
      S_TRACE, S_FETCH, S_EMIT, S_WAIT: pool_ra = parent_r;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      wall_r <= '0;
      closed_r <= '0;
      out_valid_r <= 1'b0;
      node_cnt_r <= '0;
      heap_cnt_r <= '0;
    end else begin
      if (out_xfer) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            tx_r <= in_d.target_x;
            ty_r <= in_d.target_y;
            cur_cell_r <= {in_d.cell_y, in_d.cell_x};
            if (in_d.kind == KIND_WRITE) begin
              wall_r[{in_d.cell_y, in_d.cell_x}] <= in_d.wall;
            end else if (in_d.cell_x == in_d.target_x && in_d.cell_y == in_d.target_y) begin
              out_valid_r <= 1'b1;
              out_r <= '{ST_AT_TARGET, '0, '0, 1'b1};
            end else if (wall_r[{in_d.target_y, in_d.target_x}]) begin
              out_valid_r <= 1'b1;
              out_r <= '{ST_BLOCKED, '0, '0, 1'b1};
            end else begin
              closed_r <= '0;
              node_cnt_r <= '0;
              heap_cnt_r <= '0;
              state_r <= S_CLEAR;
            end
          end
        end
        S_CLEAR: begin
          node_cnt_r <= CntW'(1);
          heap_cnt_r <= CntW'(1);
          state_r <= S_SCAN;
        end
        S_SCAN: begin
          if (heap_cnt_r == '0) begin
            out_valid_r <= 1'b1;
            out_r <= '{ST_NO_PATH, '0, '0, 1'b1};
            state_r <= S_WAIT;
          end else begin
            scan_r <= '0;
            best_ok_r <= 1'b0;
            state_r <= S_SCANRD;
          end
        end
        // sweep: cycle A reads heap entry, cycle B reads its node
        S_SCANRD: begin
          state_r <= S_NBR;
          nbr_r <= '0;
          emit_cnt_r <= '0;
          has_parent_r <= 1'b0;
          // reuse S_NBR encoding as second half of the sweep via emit_cnt_r
        end
        S_NBR: begin
          if (emit_cnt_r == '0) begin
            // pool read issued from heap_rd_r; wait for pool_rd_r
            emit_cnt_r <= 6'd1;
          end else if (emit_cnt_r == 6'd1) begin
            if (!best_ok_r || pool_rd_r.f < best_f_r ||
                (pool_rd_r.f == best_f_r && heap_rd_r < best_idx_r)) begin
              best_ok_r <= 1'b1;
              best_f_r <= pool_rd_r.f;
              best_idx_r <= heap_rd_r;
              best_pos_r <= scan_r[PoolAw-1:0];
            end
            if (last_scan) begin
              state_r <= S_POP;
            end else begin
              scan_r <= scan_r + 1'b1;
              emit_cnt_r <= '0;
              state_r <= S_SCANRD;
            end
          end else begin
            // neighbor walk
            if (nbr_ok && pool_room) begin
              state_r <= S_ADD;
            end else if (nbr_r == 3'd7) begin
              state_r <= S_SCAN;
            end else begin
              nbr_r <= nbr_r + 1'b1;
            end
          end
        end
        S_POP: state_r <= S_CUR;
        S_CUR: begin
          heap_cnt_r <= heap_cnt_r - 1'b1;
          cur_r <= best_idx_r;
          state_r <= S_TRACE;
          emit_cnt_r <= '0;
          has_parent_r <= 1'b0;
        end
        S_TRACE: begin
          // pool_rd_r now holds the popped node
          if (!has_parent_r) begin
            cur_cell_r <= pool_rd_r.pos;
            cur_g_r <= pool_rd_r.g;
            if (pool_rd_r.pos == {ty_r, tx_r}) begin
              has_parent_r <= pool_rd_r.has_parent;
              parent_r <= pool_rd_r.parent;
              if (!pool_rd_r.has_parent) begin
                out_valid_r <= 1'b1;
                out_r <= '{ST_NO_PATH, '0, '0, 1'b1};
                state_r <= S_WAIT;
              end else begin
                // hold the item until its parent shows whether it ends the path
                out_r <= '{ST_PATH, pool_rd_r.pos[CoordW-1:0],
                           pool_rd_r.pos[CellW-1:CoordW], 1'b0};
                emit_cnt_r <= 6'd1;
                state_r <= S_FETCH;
              end
            end else if (closed_r[pool_rd_r.pos]) begin
              state_r <= S_SCAN;
            end else begin
              closed_r[pool_rd_r.pos] <= 1'b1;
              nbr_r <= '0;
              emit_cnt_r <= 6'd2;
              state_r <= S_NBR;
            end
          end
        end
        S_ADD: begin
          node_cnt_r <= node_cnt_r + 1'b1;
          heap_cnt_r <= heap_cnt_r + 1'b1;
          if (nbr_r == 3'd7) begin
            state_r <= S_SCAN;
          end else begin
            nbr_r <= nbr_r + 1'b1;
            state_r <= S_NBR;
          end
        end
        S_FETCH: state_r <= S_EMIT;
        // pool_rd_r holds the parent of the item in out_r
        S_EMIT: begin
          out_r.last <= !pool_rd_r.has_parent || emit_cnt_r == 6'(MaxOut);
          out_valid_r <= 1'b1;
          state_r <= S_WAIT;
        end
        S_WAIT: begin
          if (out_xfer) begin
            if (out_r.last) begin
              state_r <= S_IDLE;
            end else begin
              out_r <= '{ST_PATH, pool_rd_r.pos[CoordW-1:0],
                         pool_rd_r.pos[CellW-1:CoordW], 1'b0};
              parent_r <= pool_rd_r.parent;
              emit_cnt_r <= emit_cnt_r + 1'b1;
              state_r <= S_FETCH;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `GAP_ASSERT_IMP(a_rdy_idle, in_ch.ready, state_r == S_IDLE)
  `GAP_ASSERT_IMP(a_heap_le_node, state_r == S_SCAN, heap_cnt_r <= node_cnt_r)
  `GAP_ASSERT_NEXT(a_add_grows, state_r == S_ADD, node_cnt_r == $past(node_cnt_r) + 1'b1)
  `GAP_ASSERT_IMP(a_last_status, out_valid_r && out_r.status != ST_PATH, out_r.last)
endmodule
